[sv/dlts_pkg.sv]
// ----------------------------------------------------------------------------
// dlts_pkg
// Shared types and constants for the delta-list task scheduler.
// ----------------------------------------------------------------------------
package dlts_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int FUNC_W  = 2;
  localparam int ID_W    = 8;
  localparam int TIME_W  = 16;
  localparam int PEND_W  = 8;
  localparam int STAT_W  = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_ID_ZERO = 2'd2;

  localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};

  typedef struct packed {
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] period;
    logic [PEND_W-1:0] pending;
  } entry_t;

  typedef enum logic [1:0] {
    LOP_NONE,
    LOP_WRITE,
    LOP_INSERT,
    LOP_REMOVE
  } list_op_kind_t;

  typedef struct packed {
    list_op_kind_t    kind;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } list_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FIX,
    S_INSERT,
    S_DONE
  } state_t;

endpackage

[sv/dlts_in_if.sv]
// ----------------------------------------------------------------------------
// dlts_in_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface dlts_in_if import dlts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   task_id;
  logic [TIME_W-1:0] start_delay;
  logic [TIME_W-1:0] repeat_period;

  modport source (output valid, func, task_id, start_delay, repeat_period, input ready);
  modport sink   (input valid, func, task_id, start_delay, repeat_period, output ready);
endinterface

[sv/dlts_out_if.sv]
// ----------------------------------------------------------------------------
// dlts_out_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface dlts_out_if import dlts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   fired_task;
  logic              fired;
  logic [STAT_W-1:0] status;

  modport source (output valid, fired_task, fired, status, input ready);
  modport sink   (input valid, fired_task, fired, status, output ready);
endinterface

[sv/dlts_list.sv]
// ----------------------------------------------------------------------------
// dlts_list
// Entry storage for the delta list: fill count, one indexed read port and the
// head, whole-entry write, insert with shift up and head removal with shift down.
// ----------------------------------------------------------------------------
module dlts_list import dlts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  list_op_t         op,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_entry,
  output entry_t           head,
  output logic [CNT_W-1:0] count
);

  entry_t           ent_r   [MAX_ENTRIES];
  entry_t           ent_nxt [MAX_ENTRIES];
  logic [CNT_W-1:0] count_r, count_nxt;

  assign rd_entry = ent_r[rd_idx];
  assign head     = ent_r[0];
  assign count    = count_r;

  always_comb begin
    count_nxt = count_r;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      ent_nxt[j] = ent_r[j];
      unique case (op.kind)
        LOP_WRITE: begin
          if (IDX_W'(j) == op.idx) ent_nxt[j] = op.entry;
        end
        LOP_INSERT: begin
          if (IDX_W'(j) == op.idx) begin
            ent_nxt[j] = op.entry;
          end else if (IDX_W'(j) > op.idx && CNT_W'(j) <= count_r) begin
            ent_nxt[j] = ent_r[(j == 0) ? 0 : j - 1];
          end
        end
        LOP_REMOVE: begin
          if (j < MAX_ENTRIES - 1) ent_nxt[j] = ent_r[(j == MAX_ENTRIES - 1) ? j : j + 1];
        end
        default: begin
        end
      endcase
    end
    unique case (op.kind)
      LOP_INSERT: count_nxt = count_r + CNT_W'(1);
      LOP_REMOVE: count_nxt = count_r - CNT_W'(1);
      default:    count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_ENTRIES; j++) ent_r[j] <= ent_nxt[j];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("list fill count beyond capacity");

  remove_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    op.kind == LOP_REMOVE |-> count_r != '0)
    else $error("head removed from empty list");

  insert_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    op.kind == LOP_INSERT |-> (count_r < CNT_W'(MAX_ENTRIES) && CNT_W'(op.idx) <= count_r))
    else $error("insert into full list or past its end");

endmodule

[sv/delta_list_task_scheduler.sv]
// ----------------------------------------------------------------------------
// delta_list_task_scheduler
// Cooperative task timer kept as a sorted delta list of timed tasks.
//
//   channel  dir  handshake         payload
//   in_ch    in   valid/ready       func, task_id, start_delay, repeat_period
//   out_ch   out  valid/ready       fired_task, fired, status
//
// Tick, unused code, rejected add or a dispatch with nothing to re-insert:
// the result goes through the done state into the output register. An add,
// or a dispatch that re-inserts a periodic task, walks the list one entry per
// cycle through the single shared 16-bit subtractor, then passes the fix,
// insert and done steps when it lands ahead of an entry, or insert and done
// when appended. The block returns to idle, ready for the next command, as
// the result is registered; a result still waiting in the output register
// holds the block in its done state until the transaction goes. Reset is
// synchronous, active low, and empties the list at once.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler import dlts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dlts_in_if.sink           in_ch,
  dlts_out_if.source        out_ch
);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [TIME_W-1:0] rest_r, rest_nxt;
  logic [TIME_W-1:0] period_r, period_nxt;
  logic [ID_W-1:0]   res_task_r, res_task_nxt;
  logic              res_fired_r, res_fired_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_task_r, out_task_nxt;
  logic              out_fired_r, out_fired_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;

  list_op_t          op;
  entry_t            rd_entry, head, wr_entry;
  logic [CNT_W-1:0]  count;

  // shared subtractor
  logic [TIME_W-1:0] ua, ub, udiff;
  logic              uborrow;

  assign {uborrow, udiff} = {1'b0, ua} - {1'b0, ub};

  dlts_list u_list (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .rd_idx   (i_r),
    .rd_entry (rd_entry),
    .head     (head),
    .count    (count)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.fired_task = out_task_r;
  assign out_ch.fired      = out_fired_r;
  assign out_ch.status     = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    id_nxt         = id_r;
    rest_nxt       = rest_r;
    period_nxt     = period_r;
    res_task_nxt   = res_task_r;
    res_fired_nxt  = res_fired_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_task_nxt   = out_task_r;
    out_fired_nxt  = out_fired_r;
    out_status_nxt = out_status_r;
    op             = '{kind: LOP_NONE, idx: '0, entry: '0};
    ua             = '0;
    ub             = '0;
    wr_entry       = head;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          res_task_nxt   = '0;
          res_fired_nxt  = 1'b0;
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
          i_nxt          = '0;
          unique case (in_ch.func)
            FUNC_ADD: begin
              if (count == CNT_W'(MAX_ENTRIES)) begin
                res_status_nxt = ST_FULL;
              end else if (in_ch.task_id == '0) begin
                res_status_nxt = ST_ID_ZERO;
              end else begin
                id_nxt     = in_ch.task_id;
                rest_nxt   = in_ch.start_delay;
                period_nxt = in_ch.repeat_period;
                state_nxt  = S_WALK;
              end
            end
            FUNC_TICK: begin
              if (count != '0) begin
                ua = head.delta;
                ub = TIME_W'(1);
                if (head.delta == '0) begin
                  if (head.pending != PEND_MAX) wr_entry.pending = head.pending + PEND_W'(1);
                end else begin
                  wr_entry.delta = udiff;
                end
                op = '{kind: LOP_WRITE, idx: '0, entry: wr_entry};
              end
            end
            FUNC_DISPATCH: begin
              if (count != '0 && head.pending != '0) begin
                res_task_nxt  = head.task_id;
                res_fired_nxt = 1'b1;
                op            = '{kind: LOP_REMOVE, idx: '0, entry: '0};
                if (head.period != '0) begin
                  id_nxt     = head.task_id;
                  rest_nxt   = head.period;
                  period_nxt = head.period;
                  state_nxt  = S_WALK;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        // step past entries due no later than the remaining delay
        ua = rest_r;
        ub = rd_entry.delta;
        if (CNT_W'(i_r) == count) begin
          state_nxt = S_INSERT;
        end else if (!uborrow) begin
          rest_nxt = udiff;
          i_nxt    = i_r + IDX_W'(1);
        end else begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        // successor keeps only what lies beyond the new entry
        ua             = rd_entry.delta;
        ub             = rest_r;
        wr_entry       = rd_entry;
        wr_entry.delta = udiff;
        op             = '{kind: LOP_WRITE, idx: i_r, entry: wr_entry};
        state_nxt      = S_INSERT;
      end
      S_INSERT: begin
        op = '{kind: LOP_INSERT, idx: i_r,
               entry: '{task_id: id_r, delta: rest_r, period: period_r, pending: '0}};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_task_nxt   = res_task_r;
          out_fired_nxt  = res_fired_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    id_r         <= id_nxt;
    rest_r       <= rest_nxt;
    period_r     <= period_nxt;
    res_task_r   <= res_task_nxt;
    res_fired_r  <= res_fired_nxt;
    res_status_r <= res_status_nxt;
    out_task_r   <= out_task_nxt;
    out_fired_r  <= out_fired_nxt;
    out_status_r <= out_status_nxt;
  end

  one_cmd_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("command accepted while previous one still in flight");

  fired_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fired_r) |-> (out_status_r == ST_OK && out_task_r != '0))
    else $error("fired result with bad status or empty task id");

  insert_grows_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INSERT |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list");

  walk_stays_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK || state_r == S_FIX) |-> CNT_W'(i_r) <= count)
    else $error("walk index past end of list");

endmodule

[test/tb_delta_list_task_scheduler.sv]
// ----------------------------------------------------------------------------
// tb_delta_list_task_scheduler
// Self-checking bench for the delta-list task scheduler. Commands are driven
// on the input channel; a scoreboard keeps its own copy of the timed-task list
// and predicts every result, which is then checked field by field.
// ----------------------------------------------------------------------------
module tb_delta_list_task_scheduler;
  import dlts_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int TICK_BURST = 280;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] start_delay;
    logic [TIME_W-1:0] repeat_period;
  } sched_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   fired_task;
    logic              fired;
    logic [STAT_W-1:0] status;
  } sched_result_t;

  // Keeps a shadow of the task list and the queue of results still owed.
  class fire_scoreboard;
    logic [ID_W-1:0]   slot_id[MAX_ENTRIES];
    logic [TIME_W-1:0] slot_delta[MAX_ENTRIES];
    logic [TIME_W-1:0] slot_period[MAX_ENTRIES];
    logic [PEND_W-1:0] slot_pend[MAX_ENTRIES];
    sched_result_t     owed_q[$];
    int mismatches;
    int commands;
    int checked;
    int fires;
    int full_rejects;
    int zero_rejects;

    function new();
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        slot_id[i]     = '0;
        slot_delta[i]  = '0;
        slot_period[i] = '0;
        slot_pend[i]   = '0;
      end
      mismatches   = 0;
      commands     = 0;
      checked      = 0;
      fires        = 0;
      full_rejects = 0;
      zero_rejects = 0;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      while (n < MAX_ENTRIES && slot_id[n] != '0) n++;
      return n;
    endfunction

    function int periodic_count();
      int n;
      n = 0;
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (slot_id[i] != '0 && slot_period[i] != '0) n++;
      return n;
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction

    // Sorted insert: lands after entries due at the same time.
    function logic [STAT_W-1:0] insert_task(logic [ID_W-1:0] id, logic [TIME_W-1:0] delay,
                                            logic [TIME_W-1:0] period);
      int fill;
      int at;
      bit found;
      logic [TIME_W-1:0] rest;
      fill  = occupancy();
      at    = fill;
      found = 0;
      rest  = delay;
      if (fill >= MAX_ENTRIES) return ST_FULL;
      if (id == '0) return ST_ID_ZERO;
      for (int i = 0; i < fill; i++) begin
        if (!found) begin
          if (slot_delta[i] <= rest) begin
            rest = rest - slot_delta[i];
          end else begin
            at            = i;
            slot_delta[i] = slot_delta[i] - rest;
            found         = 1;
          end
        end
      end
      for (int i = fill; i > at; i--) begin
        slot_id[i]     = slot_id[i-1];
        slot_delta[i]  = slot_delta[i-1];
        slot_period[i] = slot_period[i-1];
        slot_pend[i]   = slot_pend[i-1];
      end
      slot_id[at]     = id;
      slot_delta[at]  = rest;
      slot_period[at] = period;
      slot_pend[at]   = '0;
      return ST_OK;
    endfunction

    function void drop_head();
      for (int i = 1; i < MAX_ENTRIES; i++) begin
        slot_id[i-1]     = slot_id[i];
        slot_delta[i-1]  = slot_delta[i];
        slot_period[i-1] = slot_period[i];
        slot_pend[i-1]   = slot_pend[i];
      end
      slot_id[MAX_ENTRIES-1]     = '0;
      slot_delta[MAX_ENTRIES-1]  = '0;
      slot_period[MAX_ENTRIES-1] = '0;
      slot_pend[MAX_ENTRIES-1]   = '0;
    endfunction

    function void note_command(sched_cmd_t c);
      sched_result_t r;
      logic [ID_W-1:0]   head_id;
      logic [TIME_W-1:0] head_period;
      logic [STAT_W-1:0] dummy;
      r = '0;
      commands++;
      case (c.func)
        FUNC_ADD: begin
          r.status = insert_task(c.task_id, c.start_delay, c.repeat_period);
        end
        FUNC_TICK: begin
          if (slot_id[0] != '0) begin
            if (slot_delta[0] == '0) begin
              if (slot_pend[0] != PEND_MAX) slot_pend[0] = slot_pend[0] + 1'b1;
            end else begin
              slot_delta[0] = slot_delta[0] - 1'b1;
            end
          end
        end
        FUNC_DISPATCH: begin
          if (slot_id[0] != '0 && slot_pend[0] != '0) begin
            head_id      = slot_id[0];
            head_period  = slot_period[0];
            r.fired_task = head_id;
            r.fired      = 1'b1;
            drop_head();
            // leftover pending runs are lost; periodic tasks go back in
            if (head_period != '0) dummy = insert_task(head_id, head_period, head_period);
          end
        end
        default: ;
      endcase
      owed_q.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp_r;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result: fired_task=%0d fired=%0d status=%0d",
                 $time, got.fired_task, got.fired, got.status);
        mismatches++;
        return;
      end
      exp_r = owed_q.pop_front();
      checked++;
      if (exp_r.fired) fires++;
      if (exp_r.status == ST_FULL) full_rejects++;
      if (exp_r.status == ST_ID_ZERO) zero_rejects++;
      if (got.fired_task !== exp_r.fired_task) begin
        $display("%0t: fired_task mismatch: expected %0d, actual %0d",
                 $time, exp_r.fired_task, got.fired_task);
        mismatches++;
      end
      if (got.fired !== exp_r.fired) begin
        $display("%0t: fired mismatch: expected %0d, actual %0d",
                 $time, exp_r.fired, got.fired);
        mismatches++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, exp_r.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  dlts_in_if  in_ch ();
  dlts_out_if out_ch ();

  delta_list_task_scheduler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fire_scoreboard sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #3_200_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: ready decided at the falling edge, transaction taken at the rising edge.
  initial begin : result_sink
    sched_result_t got;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n !== 1'b1) begin
        out_ch.ready = 1'b0;
      end else if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= stall_pct);
      end
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.fired_task = out_ch.fired_task;
        got.fired      = out_ch.fired;
        got.status     = out_ch.status;
        sb.check_result(got);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic drive_command(sched_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.func          = c.func;
    in_ch.task_id       = c.task_id;
    in_ch.start_delay   = c.start_delay;
    in_ch.repeat_period = c.repeat_period;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_command(c);
    @(negedge clk);
  endtask

  task automatic issue(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                       logic [TIME_W-1:0] delay, logic [TIME_W-1:0] period);
    sched_cmd_t c;
    c.func          = func;
    c.task_id       = id;
    c.start_delay   = delay;
    c.repeat_period = period;
    drive_command(c);
  endtask

  function automatic logic [TIME_W-1:0] pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 70) return TIME_W'($urandom_range(6));
    if (r < 95) return TIME_W'($urandom_range(40, 7));
    return TIME_W'($urandom_range(300, 41));
  endfunction

  // Periodic tasks never leave the list, so their number is capped to keep
  // room for one-shot traffic.
  function automatic sched_cmd_t random_command(int fill, int periodic);
    sched_cmd_t c;
    int pick;
    int r;
    c    = '0;
    pick = $urandom_range(99);
    if (pick < 1) begin
      c.func          = FUNC_UNUSED;
      c.task_id       = ID_W'($urandom);
      c.start_delay   = TIME_W'($urandom);
      c.repeat_period = TIME_W'($urandom);
    end else if (pick < ((fill >= MAX_ENTRIES - 1) ? 18 : 42)) begin
      c.func = FUNC_ADD;
      if (fill >= MAX_ENTRIES) begin
        // rejected anyway: use the full field ranges
        c.task_id       = ID_W'($urandom);
        c.start_delay   = TIME_W'($urandom);
        c.repeat_period = TIME_W'($urandom);
      end else begin
        c.task_id     = ID_W'($urandom_range(255, 1));
        c.start_delay = pick_delay();
        r = $urandom_range(99);
        if (periodic < 6 && r < 12) c.repeat_period = TIME_W'($urandom_range(12, 1));
        else if (periodic < 6 && r < 15) c.repeat_period = TIME_W'($urandom_range(200, 13));
        else c.repeat_period = '0;
      end
      if ($urandom_range(24) == 0) begin
        c.task_id     = '0;
        c.start_delay = TIME_W'($urandom);
      end
    end else begin
      c.func = (pick < 78) ? FUNC_TICK : FUNC_DISPATCH;
      if ($urandom_range(9) == 0) begin
        c.task_id       = ID_W'($urandom);
        c.start_delay   = TIME_W'($urandom);
        c.repeat_period = TIME_W'($urandom);
      end
    end
    return c;
  endfunction

  task automatic run_random(int count);
    repeat (count) drive_command(random_command(sb.occupancy(), sb.periodic_count()));
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.func          = FUNC_ADD;
    in_ch.task_id       = '0;
    in_ch.start_delay   = '0;
    in_ch.repeat_period = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty list, unused code, rejects, ordering at equal times
    issue(FUNC_TICK, 8'h00, 16'h0000, 16'h0000);
    issue(FUNC_DISPATCH, 8'hFF, 16'hFFFF, 16'hFFFF);
    issue(FUNC_UNUSED, 8'hA5, 16'h5A5A, 16'hA5A5);
    issue(FUNC_ADD, 8'h00, 16'hFFFF, 16'hFFFF);
    issue(FUNC_ADD, 8'hFF, 16'hFFFF, 16'hFFFF);
    issue(FUNC_ADD, 8'h01, 16'h0000, 16'h0000);
    issue(FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000);
    issue(FUNC_TICK, 8'h00, 16'h0000, 16'h0000);
    issue(FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000);
    issue(FUNC_ADD, 8'h02, 16'd3, 16'd2);
    issue(FUNC_ADD, 8'h03, 16'd3, 16'd0);
    issue(FUNC_ADD, 8'h04, 16'd1, 16'd0);
    issue(FUNC_ADD, 8'h05, 16'd0, 16'd1);
    repeat (2) issue(FUNC_TICK, 8'h00, 16'h0000, 16'h0000);
    repeat (2) issue(FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000);
    repeat (3) issue(FUNC_TICK, 8'h00, 16'h0000, 16'h0000);
    repeat (3) issue(FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000);

    // back to back, then a long tick run to saturate the head's run count
    run_random(240);
    issue(FUNC_ADD, 8'h77, 16'd0, 16'd0);
    repeat (TICK_BURST) issue(FUNC_TICK, 8'h00, 16'h0000, 16'h0000);
    repeat (2) issue(FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000);

    send_idle_pct = 80;
    run_random(240);
    // receiver holds off while commands keep coming, then a full drain
    send_idle_pct = 0;
    hold_left     = 300;
    run_random(40);
    in_ch.valid = 1'b0;
    wait_drained();

    send_idle_pct = 0;
    stall_pct     = 80;
    run_random(240);

    send_idle_pct = 11;
    stall_pct     = 11;
    run_random(240);
    in_ch.valid = 1'b0;

    wait_drained();
    repeat (40) @(negedge clk);

    $display("Ran %0d commands, checked %0d results: %0d dispatch fires,",
             sb.commands, sb.checked, sb.fires);
    $display("  %0d full-list rejects and %0d zero-id rejects, across four idling phases.",
             sb.full_rejects, sb.zero_rejects);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/dlts_pkg.sv
sv/dlts_in_if.sv
sv/dlts_out_if.sv
sv/dlts_list.sv
sv/delta_list_task_scheduler.sv
test/tb_delta_list_task_scheduler.sv
